/* hw/rtl/smc_pkg.sv */
`timescale 1ns / 1ps

package smc_pkg;

  // field widths
  localparam int unsigned OP_W       = 3;
  localparam int unsigned TOD_W      = 24;
  localparam int unsigned SPEED_W    = 16;
  localparam int unsigned SPM_W      = 13;
  localparam int unsigned TCLK_W     = 28;
  localparam int unsigned LIM_W      = 32;
  localparam int unsigned STEPS_W    = 32;
  localparam int unsigned PRESC_W    = 32;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned OUT_POS_W  = 32;

  // stream and config words
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 72;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  // shared multiplier: |distance| or speed times steps_per_mm
  localparam int unsigned MUL_A_W    = 24;
  localparam int unsigned MUL_P_W    = MUL_A_W + SPM_W;

  // prescaler divider: (clock << 8) / (speed * steps_per_mm)
  localparam int unsigned DIVIDEND_W = TCLK_W + 8;
  localparam int unsigned DIVISOR_W  = SPEED_W + SPM_W;
  localparam int unsigned DIV_CNT_W  = $clog2(DIVIDEND_W + 1);

  // register reset values
  localparam logic [SPM_W-1:0]         SPM_RESET  = 13'd200;
  localparam logic [TCLK_W-1:0]        TCLK_RESET = 28'd50000000;
  localparam logic signed [LIM_W-1:0]  MIN_RESET  = 32'sh8000_0000;
  localparam logic signed [LIM_W-1:0]  MAX_RESET  = 32'sh7FFF_FFFF;

  typedef enum logic [OP_W-1:0] {
    OP_PULSE_DONE = 3'd0,
    OP_ENABLE     = 3'd1,
    OP_DISABLE    = 3'd2,
    OP_MOVE_ABS   = 3'd3,
    OP_MOVE_REL   = 3'd4,
    OP_END_STOP   = 3'd5
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_DISABLED = 2'd1,
    ST_BUSY     = 2'd2,
    ST_RANGE    = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEPS_PER_MM = 2'd0,
    CFG_TIMER_CLOCK  = 2'd1,
    CFG_MIN_POSITION = 2'd2,
    CFG_MAX_POSITION = 2'd3
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_DIST,
    S_MUL_DEN,
    S_DIFF,
    S_STEPS,
    S_RANGE,
    S_DIV_WAIT,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic [SPM_W-1:0]        steps_per_mm;
    logic [TCLK_W-1:0]       timer_clock_hz;
    logic signed [LIM_W-1:0] min_position;
    logic signed [LIM_W-1:0] max_position;
  } cfg_t;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [DIVIDEND_W-1:0] quotient;
  } div_rsp_t;

endpackage

/* hw/rtl/stepper_move_controller.sv */
`timescale 1ns / 1ps

// Single-axis step/dir move controller.
// Commands enter on the s_axis channel (op in tuser, distance/target and
// speed in tdata); each command gives exactly one result word on m_axis.
// Configuration registers (steps_per_mm, timer clock, position limits) are
// written over the cfg channel; the user must do so only while no command
// is in flight, as the block itself does not enforce it. A move runs two
// passes through one shared multiplier, a difference, rounding and range
// stage, then a restoring divider that retires one quotient bit per cycle;
// a rejected or zero-speed move skips the divider. Enable, disable, pulse
// done and end stop go from accept straight to the result.
// One command is in flight at a time; tready is high only when the
// sequencer is idle, and a new command may be taken while the last result
// still waits in the output register.
// When the receiver stalls, the finished result is held until the output
// register frees up; the position state is only updated at that point.
// Reset clears position, remaining steps and the flags, loads the register
// defaults and leaves the output channel empty.
module stepper_move_controller #(
  parameter int unsigned POSITION_WIDTH = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // command word
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // [23:0] target_or_distance, [39:24] speed
  input  logic [smc_pkg::IN_DATA_W-1:0]   s_axis_tdata_i,
  // [2:0] op
  input  logic [smc_pkg::OP_W-1:0]        s_axis_tuser_i,
  // result word
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // [1:0] status, [33:2] prescaler, [34] prescaler_write, [35] direction,
  // [36] enabled, [37] moving, [69:38] position_steps, [70] start_pulses,
  // [71] stop_pulses
  output logic [smc_pkg::OUT_DATA_W-1:0]  m_axis_tdata_o,
  // configuration writes
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [smc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [smc_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int unsigned PosW  = POSITION_WIDTH;
  localparam int unsigned DistW = smc_pkg::MUL_P_W + 1;
  localparam int unsigned DiffW = (((PosW + 8) > DistW) ? (PosW + 8) : DistW) + 1;
  localparam int unsigned TgtW  = ((PosW > (smc_pkg::STEPS_W + 1)) ?
                                   PosW : (smc_pkg::STEPS_W + 1)) + 1;
  localparam int unsigned SW    = smc_pkg::STEPS_W;
  localparam int unsigned PW    = smc_pkg::PRESC_W;

  smc_pkg::cfg_t     cfg;
  smc_pkg::div_req_t div_req;
  smc_pkg::div_rsp_t div_rsp;
  smc_pkg::state_e   state_q, state_d;

  // latched command
  logic [smc_pkg::OP_W-1:0]        op_q;
  logic signed [smc_pkg::TOD_W-1:0] tod_q;
  logic [smc_pkg::SPEED_W-1:0]     speed_q;

  // move datapath registers
  logic [smc_pkg::MUL_P_W-1:0]     prod_q;
  logic [smc_pkg::DIVISOR_W-1:0]   den_q;
  logic signed [DiffW-1:0]         diff_q;
  logic [SW-1:0]                   steps_q;
  logic                            ndir_q;
  smc_pkg::status_e                status_q;

  // axis state
  logic signed [PosW-1:0]          pos_q, pos_d;
  logic [SW-1:0]                   rem_q, rem_d;
  logic                            dir_q, dir_d;
  logic                            moving_q, moving_d;
  logic                            en_q, en_d;

  // output register
  logic                            out_valid_q;
  logic [smc_pkg::OUT_DATA_W-1:0]  out_data_q, out_data_d;

  // control
  logic                            in_fire;
  logic                            out_load;
  logic                            is_move;
  logic                            move_go;

  // combinational datapath
  logic [smc_pkg::MUL_A_W-1:0]     tod_mag;
  logic [smc_pkg::MUL_A_W-1:0]     mul_a;
  logic [smc_pkg::MUL_P_W-1:0]     mul_p;
  logic signed [DistW-1:0]         dist_s;
  logic signed [DiffW-1:0]         pos256;
  logic signed [DiffW-1:0]         diff_d;
  logic [DiffW-1:0]                mag;
  logic [DiffW:0]                  mag_r;
  logic [DiffW:0]                  mag_sh;
  logic [SW-1:0]                   steps_d;
  logic signed [TgtW-1:0]          pos_t;
  logic signed [TgtW-1:0]          steps_t;
  logic signed [TgtW-1:0]          tgt;
  logic signed [TgtW-1:0]          min_t;
  logic signed [TgtW-1:0]          max_t;
  smc_pkg::status_e                status_d;
  logic [SW-1:0]                   rem_dec;
  logic [PW-1:0]                   presc;
  logic                            pwrite;
  logic                            start_p;
  logic                            stop_p;
  logic [63:0]                     pos_ext;

  smc_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  smc_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  assign s_axis_tready_o = (state_q == smc_pkg::S_IDLE);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign out_load        = (state_q == smc_pkg::S_FINISH) &&
                           (!out_valid_q || m_axis_tready_i);
  assign is_move         = (op_q == smc_pkg::OP_MOVE_ABS) ||
                           (op_q == smc_pkg::OP_MOVE_REL);
  assign move_go         = is_move && (status_q == smc_pkg::ST_OK) &&
                           (speed_q != '0);

  // shared multiplier: distance pass, then speed pass
  assign tod_mag = tod_q[smc_pkg::TOD_W-1] ? smc_pkg::MUL_A_W'(-tod_q) :
                                             smc_pkg::MUL_A_W'(tod_q);
  assign mul_a   = (state_q == smc_pkg::S_MUL_DIST) ? tod_mag :
                                                      smc_pkg::MUL_A_W'(speed_q);
  assign mul_p   = mul_a * smc_pkg::MUL_P_W'(cfg.steps_per_mm);

  // signed move in 1/256 steps
  assign dist_s = tod_q[smc_pkg::TOD_W-1] ? -$signed({1'b0, prod_q}) :
                                             $signed({1'b0, prod_q});
  assign pos256 = DiffW'(pos_q) <<< 8;
  assign diff_d = (op_q == smc_pkg::OP_MOVE_ABS) ? (DiffW'(dist_s) - pos256) :
                                                   DiffW'(dist_s);

  // round half away from zero, saturate to 32 bits
  assign mag     = diff_q[DiffW-1] ? DiffW'(-diff_q) : DiffW'(diff_q);
  assign mag_r   = (DiffW + 1)'(mag) + (DiffW + 1)'(128);
  assign mag_sh  = mag_r >> 8;
  assign steps_d = (|mag_sh[DiffW:SW]) ? {SW{1'b1}} : mag_sh[SW-1:0];

  // relative target range check
  assign pos_t   = TgtW'(pos_q);
  assign steps_t = TgtW'($signed({1'b0, steps_q}));
  assign tgt     = ndir_q ? (pos_t - steps_t) : (pos_t + steps_t);
  assign min_t   = TgtW'(cfg.min_position);
  assign max_t   = TgtW'(cfg.max_position);

  always_comb begin
    if (!en_q) begin
      status_d = smc_pkg::ST_DISABLED;
    end else if (moving_q) begin
      status_d = smc_pkg::ST_BUSY;
    end else if ((op_q == smc_pkg::OP_MOVE_REL) && ((tgt < min_t) || (tgt > max_t))) begin
      status_d = smc_pkg::ST_RANGE;
    end else begin
      status_d = smc_pkg::ST_OK;
    end
  end

  // sequencer
  always_comb begin
    state_d          = state_q;
    div_req.start    = 1'b0;
    div_req.dividend = {cfg.timer_clock_hz, 8'h00};
    div_req.divisor  = den_q;
    unique case (state_q)
      smc_pkg::S_IDLE: begin
        if (in_fire) begin
          if ((s_axis_tuser_i == smc_pkg::OP_MOVE_ABS) ||
              (s_axis_tuser_i == smc_pkg::OP_MOVE_REL)) begin
            state_d = smc_pkg::S_MUL_DIST;
          end else begin
            state_d = smc_pkg::S_FINISH;
          end
        end
      end
      smc_pkg::S_MUL_DIST: state_d = smc_pkg::S_MUL_DEN;
      smc_pkg::S_MUL_DEN:  state_d = smc_pkg::S_DIFF;
      smc_pkg::S_DIFF:     state_d = smc_pkg::S_STEPS;
      smc_pkg::S_STEPS:    state_d = smc_pkg::S_RANGE;
      smc_pkg::S_RANGE: begin
        if ((status_d == smc_pkg::ST_OK) && (speed_q != '0)) begin
          div_req.start = 1'b1;
          state_d       = smc_pkg::S_DIV_WAIT;
        end else begin
          state_d = smc_pkg::S_FINISH;
        end
      end
      smc_pkg::S_DIV_WAIT: begin
        if (div_rsp.done) begin
          state_d = smc_pkg::S_FINISH;
        end
      end
      smc_pkg::S_FINISH: begin
        if (out_load) begin
          state_d = smc_pkg::S_IDLE;
        end
      end
      default: state_d = smc_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= smc_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // command and move datapath registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q    <= s_axis_tuser_i;
      tod_q   <= $signed(s_axis_tdata_i[smc_pkg::TOD_W-1:0]);
      speed_q <= s_axis_tdata_i[smc_pkg::TOD_W +: smc_pkg::SPEED_W];
    end
    if (state_q == smc_pkg::S_MUL_DIST) begin
      prod_q <= mul_p;
    end
    if (state_q == smc_pkg::S_MUL_DEN) begin
      den_q <= mul_p[smc_pkg::DIVISOR_W-1:0];
    end
    if (state_q == smc_pkg::S_DIFF) begin
      diff_q <= diff_d;
    end
    if (state_q == smc_pkg::S_STEPS) begin
      steps_q <= steps_d;
      ndir_q  <= diff_q[DiffW-1];
    end
    if (state_q == smc_pkg::S_RANGE) begin
      status_q <= status_d;
    end
  end

  // state update and result word
  assign rem_dec = rem_q - SW'(1);
  assign presc   = (|div_rsp.quotient[smc_pkg::DIVIDEND_W-1:PW]) ?
                   {PW{1'b1}} : div_rsp.quotient[PW-1:0];

  always_comb begin
    pos_d    = pos_q;
    rem_d    = rem_q;
    dir_d    = dir_q;
    moving_d = moving_q;
    en_d     = en_q;
    pwrite   = 1'b0;
    start_p  = 1'b0;
    stop_p   = 1'b0;
    case (op_q)
      smc_pkg::OP_PULSE_DONE: begin
        if (moving_q) begin
          pos_d = dir_q ? (pos_q - PosW'(1)) : (pos_q + PosW'(1));
          rem_d = rem_dec;
          if (rem_dec == '0) begin
            moving_d = 1'b0;
            en_d     = 1'b0;
            stop_p   = 1'b1;
          end
        end
      end
      smc_pkg::OP_ENABLE:  en_d = 1'b1;
      smc_pkg::OP_DISABLE: en_d = 1'b0;
      smc_pkg::OP_MOVE_ABS, smc_pkg::OP_MOVE_REL: begin
        if (move_go) begin
          pwrite = 1'b1;
          dir_d  = ndir_q;
          rem_d  = steps_q;
          if (steps_q != '0) begin
            moving_d = 1'b1;
            start_p  = 1'b1;
          end
        end
      end
      smc_pkg::OP_END_STOP: begin
        moving_d = 1'b0;
        rem_d    = '0;
        en_d     = 1'b0;
        stop_p   = 1'b1;
      end
      default: begin
        pwrite = 1'b0;
      end
    endcase
  end

  assign pos_ext = 64'(unsigned'(pos_d));

  always_comb begin
    out_data_d = {stop_p, start_p, pos_ext[smc_pkg::OUT_POS_W-1:0], moving_d, en_d,
                  dir_d, pwrite, (pwrite ? presc : {PW{1'b0}}),
                  (is_move ? status_q : smc_pkg::ST_OK)};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      rem_q    <= '0;
      dir_q    <= 1'b0;
      moving_q <= 1'b0;
      en_q     <= 1'b0;
    end else if (out_load) begin
      pos_q    <= pos_d;
      rem_q    <= rem_d;
      dir_q    <= dir_d;
      moving_q <= moving_d;
      en_q     <= en_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

`ifndef SYNTHESIS
  a_moving_has_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    moving_q |-> (rem_q != '0))
    else $error("axis moving with no steps left");

  a_div_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == smc_pkg::S_DIV_WAIT))
    else $error("divider finished outside of its wait state");

  a_start_is_moving: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[70]) |-> m_axis_tdata_o[37])
    else $error("pulse start reported without moving flag");
`endif

endmodule

/* hw/rtl/smc_cfg_regs.sv */
`timescale 1ns / 1ps

module smc_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [smc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [smc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output smc_pkg::cfg_t                  cfg_o
);

  smc_pkg::cfg_t cfg_q;
  logic          wr_en;

  // writes are always taken
  assign cfg_ready_o = 1'b1;
  assign wr_en       = cfg_valid_i;
  assign cfg_o       = cfg_q;

  // register file with decode by index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.steps_per_mm   <= smc_pkg::SPM_RESET;
      cfg_q.timer_clock_hz <= smc_pkg::TCLK_RESET;
      cfg_q.min_position   <= smc_pkg::MIN_RESET;
      cfg_q.max_position   <= smc_pkg::MAX_RESET;
    end else if (wr_en) begin
      unique case (smc_pkg::cfg_idx_e'(cfg_index_i))
        smc_pkg::CFG_STEPS_PER_MM: begin
          cfg_q.steps_per_mm <= cfg_data_i[smc_pkg::SPM_W-1:0];
        end
        smc_pkg::CFG_TIMER_CLOCK: begin
          cfg_q.timer_clock_hz <= cfg_data_i[smc_pkg::TCLK_W-1:0];
        end
        smc_pkg::CFG_MIN_POSITION: begin
          cfg_q.min_position <= $signed(cfg_data_i[smc_pkg::LIM_W-1:0]);
        end
        smc_pkg::CFG_MAX_POSITION: begin
          cfg_q.max_position <= $signed(cfg_data_i[smc_pkg::LIM_W-1:0]);
        end
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

endmodule

/* hw/rtl/smc_div.sv */
`timescale 1ns / 1ps

module smc_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  smc_pkg::div_req_t req_i,
  output smc_pkg::div_rsp_t rsp_o
);

  localparam int unsigned NW = smc_pkg::DIVIDEND_W;
  localparam int unsigned DW = smc_pkg::DIVISOR_W;
  localparam int unsigned CW = smc_pkg::DIV_CNT_W;

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [DW-1:0] div_q, div_d;
  logic [DW-1:0] rem_q, rem_d;
  logic [NW-1:0] quot_q, quot_d;
  logic [DW:0]   rem_sh;
  logic [DW:0]   rem_sub;
  logic          fits;

  // one restoring step per cycle: shift in a dividend bit, try subtract
  assign rem_sh  = {rem_q, quot_q[NW-1]};
  assign rem_sub = rem_sh - {1'b0, div_q};
  assign fits    = (rem_sh >= {1'b0, div_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    div_d  = div_q;
    rem_d  = rem_q;
    quot_d = quot_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CW'(NW);
      div_d  = req_i.divisor;
      rem_d  = '0;
      quot_d = req_i.dividend;
    end else if (busy_q) begin
      rem_d  = fits ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
      quot_d = {quot_q[NW-2:0], fits};
      cnt_d  = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // operand and partial result registers
  always_ff @(posedge clk_i) begin
    div_q  <= div_d;
    rem_q  <= rem_d;
    quot_q <= quot_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quot_q;

endmodule

/* tb/sv/tb_stepper_move_controller.sv */
`timescale 1ns / 1ps

module tb_stepper_move_controller;

  // op codes the block leaves without effect
  localparam logic [smc_pkg::OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [smc_pkg::OP_W-1:0] OP_SPARE_7 = 3'd7;

  localparam int SETTLE_CYCLES = 48;
  localparam int PULSE_CAP     = 48;
  localparam int CYCLE_LIMIT   = 600_000;

  typedef struct packed {
    logic [smc_pkg::STATUS_W-1:0]  status;
    logic [smc_pkg::PRESC_W-1:0]   prescaler;
    logic                          presc_wr;
    logic                          dir;
    logic                          enabled;
    logic                          moving;
    logic [smc_pkg::OUT_POS_W-1:0] position;
    logic                          start;
    logic                          stop;
  } axis_result_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                           cmd_valid = 1'b0;
  logic                           s_axis_tready_o;
  logic [smc_pkg::IN_DATA_W-1:0]  cmd_data  = '0;
  logic [smc_pkg::OP_W-1:0]       cmd_op    = '0;
  logic                           m_axis_tvalid_o;
  logic                           rsp_ready = 1'b0;
  logic [smc_pkg::OUT_DATA_W-1:0] m_axis_tdata_o;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready_o;
  logic [smc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [smc_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

  // shadow of the configuration registers
  logic [smc_pkg::SPM_W-1:0]        cfg_spm  = smc_pkg::SPM_RESET;
  logic [smc_pkg::TCLK_W-1:0]       cfg_tclk = smc_pkg::TCLK_RESET;
  logic signed [smc_pkg::LIM_W-1:0] cfg_min  = smc_pkg::MIN_RESET;
  logic signed [smc_pkg::LIM_W-1:0] cfg_max  = smc_pkg::MAX_RESET;

  // predicted axis state
  logic [31:0] axis_pos       = '0;
  logic [31:0] axis_remaining = '0;
  logic        axis_dir       = 1'b0;
  logic        axis_moving    = 1'b0;
  logic        axis_enabled   = 1'b0;

  axis_result_t pending_results[$];
  axis_result_t seen_r;
  axis_result_t want_r;

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hold_left     = 0;
  int cycle_cnt     = 0;
  int fail_cnt      = 0;
  int cmds_sent     = 0;
  int results_seen  = 0;
  int moves_started = 0;
  int moves_refused = 0;
  int range_refused = 0;
  int reg_writes    = 0;

  stepper_move_controller u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (cmd_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (cmd_data),
    .s_axis_tuser_i  (cmd_op),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (rsp_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  always #5 clk_i = ~clk_i;

  // run guard
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // receiver: long hold-off first, else random stalls
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // random field values
  function automatic logic [smc_pkg::TOD_W-1:0] rand_tod();
    return smc_pkg::TOD_W'($urandom);
  endfunction

  function automatic logic [smc_pkg::SPEED_W-1:0] rand_speed();
    return smc_pkg::SPEED_W'($urandom);
  endfunction

  // next state of the axis for one command, and the word it answers with
  function automatic axis_result_t predict_axis(
      input logic [smc_pkg::OP_W-1:0] op,
      input logic signed [smc_pkg::TOD_W-1:0] tod,
      input logic [smc_pkg::SPEED_W-1:0] speed);
    axis_result_t r;
    longint pos_s;
    longint diff;
    longint tgt;
    longint unsigned mag;
    longint unsigned steps;
    longint unsigned den;
    longint unsigned quo;
    logic ndir;
    r = '0;
    case (op)
      smc_pkg::OP_PULSE_DONE: begin
        // pulses only count while a move runs
        if (axis_moving) begin
          axis_pos       = axis_dir ? axis_pos - 32'd1 : axis_pos + 32'd1;
          axis_remaining = axis_remaining - 32'd1;
          if (axis_remaining == 32'd0) begin
            axis_moving  = 1'b0;
            axis_enabled = 1'b0;
            r.stop       = 1'b1;
          end
        end
      end
      smc_pkg::OP_ENABLE:  axis_enabled = 1'b1;
      smc_pkg::OP_DISABLE: axis_enabled = 1'b0;
      smc_pkg::OP_MOVE_ABS, smc_pkg::OP_MOVE_REL: begin
        pos_s = longint'($signed(axis_pos));
        diff  = longint'(tod) * longint'(cfg_spm);
        if (op == smc_pkg::OP_MOVE_ABS) diff = diff - pos_s * 256;
        ndir  = (diff < 0);
        mag   = (diff < 0) ? longint'(-diff) : diff;
        steps = (mag + 128) >> 8;
        if (steps > 64'hFFFF_FFFF) steps = 64'hFFFF_FFFF;
        // checks go in order: disabled, busy, range, zero speed
        if (!axis_enabled) begin
          r.status = smc_pkg::ST_DISABLED;
        end else if (axis_moving) begin
          r.status = smc_pkg::ST_BUSY;
        end else begin
          if (op == smc_pkg::OP_MOVE_REL) begin
            tgt = ndir ? pos_s - longint'(steps) : pos_s + longint'(steps);
            if (tgt < longint'(cfg_min) || tgt > longint'(cfg_max)) begin
              r.status = smc_pkg::ST_RANGE;
            end
          end
          if (r.status == smc_pkg::ST_OK && speed != '0) begin
            den = 64'(speed) * 64'(cfg_spm);
            if (den == 0) begin
              quo = 64'hFFFF_FFFF;
            end else begin
              quo = (64'(cfg_tclk) << 8) / den;
              if (quo > 64'hFFFF_FFFF) quo = 64'hFFFF_FFFF;
            end
            r.prescaler    = quo[31:0];
            r.presc_wr     = 1'b1;
            axis_dir       = ndir;
            axis_remaining = steps[31:0];
            if (steps != 0) begin
              axis_moving = 1'b1;
              r.start     = 1'b1;
              moves_started++;
            end
          end
        end
        if (r.status != smc_pkg::ST_OK) moves_refused++;
        if (r.status == smc_pkg::ST_RANGE) range_refused++;
      end
      smc_pkg::OP_END_STOP: begin
        axis_moving    = 1'b0;
        axis_remaining = '0;
        axis_enabled   = 1'b0;
        r.stop         = 1'b1;
      end
      default: ;
    endcase
    r.dir      = axis_dir;
    r.enabled  = axis_enabled;
    r.moving   = axis_moving;
    r.position = axis_pos;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      fail_cnt++;
    end
  endtask

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && rsp_ready) begin
      results_seen++;
      seen_r.status    = m_axis_tdata_o[1:0];
      seen_r.prescaler = m_axis_tdata_o[33:2];
      seen_r.presc_wr  = m_axis_tdata_o[34];
      seen_r.dir       = m_axis_tdata_o[35];
      seen_r.enabled   = m_axis_tdata_o[36];
      seen_r.moving    = m_axis_tdata_o[37];
      seen_r.position  = m_axis_tdata_o[69:38];
      seen_r.start     = m_axis_tdata_o[70];
      seen_r.stop      = m_axis_tdata_o[71];
      if (pending_results.size() == 0) begin
        $error("result word with no command waiting: 0x%0h", m_axis_tdata_o);
        fail_cnt++;
      end else begin
        want_r = pending_results.pop_front();
        check_field("status", want_r.status, seen_r.status);
        check_field("prescaler", want_r.prescaler, seen_r.prescaler);
        check_field("prescaler_write", want_r.presc_wr, seen_r.presc_wr);
        check_field("direction", want_r.dir, seen_r.dir);
        check_field("enabled", want_r.enabled, seen_r.enabled);
        check_field("moving", want_r.moving, seen_r.moving);
        check_field("position_steps", want_r.position, seen_r.position);
        check_field("start_pulses", want_r.start, seen_r.start);
        check_field("stop_pulses", want_r.stop, seen_r.stop);
      end
    end
  end

  // one command word; valid stays up after the handshake
  task automatic send_cmd(input logic [smc_pkg::OP_W-1:0] op,
                          input logic [smc_pkg::TOD_W-1:0] tod,
                          input logic [smc_pkg::SPEED_W-1:0] speed);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap != 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_valid <= 1'b1;
    cmd_op    <= op;
    cmd_data  <= {speed, tod};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    pending_results.push_back(predict_axis(op, tod, speed));
    cmds_sent++;
  endtask

  // wait until every result is back and the block has gone quiet
  task automatic drain;
    cmd_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apply_config(input logic [31:0] spm, input logic [31:0] tclk,
                              input logic [31:0] min_pos, input logic [31:0] max_pos);
    logic [31:0]       vals[4];
    smc_pkg::cfg_idx_e idx;
    vals = '{spm, tclk, min_pos, max_pos};
    drain();
    for (int i = 0; i < 4; i++) begin
      idx = smc_pkg::cfg_idx_e'(i);
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= vals[i];
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
      case (idx)
        smc_pkg::CFG_STEPS_PER_MM: cfg_spm  = vals[i][smc_pkg::SPM_W-1:0];
        smc_pkg::CFG_TIMER_CLOCK:  cfg_tclk = vals[i][smc_pkg::TCLK_W-1:0];
        smc_pkg::CFG_MIN_POSITION: cfg_min  = vals[i];
        smc_pkg::CFG_MAX_POSITION: cfg_max  = vals[i];
        default: ;
      endcase
      reg_writes++;
    end
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_idling(input int send_pct, input int rx_pct);
    @(negedge clk_i);
    send_idle_pct = send_pct;
    stall_pct     = rx_pct;
    @(posedge clk_i);
  endtask

  // rejections, spare codes, a short move with disable, a long move cut by end stop
  task automatic test_command_basics;
    send_cmd(smc_pkg::OP_MOVE_ABS, 24'd100, 16'd100);
    send_cmd(smc_pkg::OP_PULSE_DONE, '0, '0);
    send_cmd(OP_SPARE_6, 24'hFFFFFF, 16'hFFFF);
    send_cmd(OP_SPARE_7, 24'h000001, 16'h0001);
    send_cmd(smc_pkg::OP_ENABLE, '0, '0);
    send_cmd(smc_pkg::OP_MOVE_REL, 24'd0, 16'd256);
    send_cmd(smc_pkg::OP_MOVE_REL, 24'd5, 16'd0);
    send_cmd(smc_pkg::OP_MOVE_REL, 24'd2, 16'hFFFF);
    send_cmd(smc_pkg::OP_MOVE_ABS, 24'd50, 16'd10);
    send_cmd(smc_pkg::OP_DISABLE, '0, '0);
    send_cmd(smc_pkg::OP_PULSE_DONE, '0, '0);
    send_cmd(smc_pkg::OP_PULSE_DONE, '0, '0);
    send_cmd(smc_pkg::OP_ENABLE, '0, '0);
    send_cmd(smc_pkg::OP_MOVE_ABS, 24'h800000, 16'd1);
    send_cmd(smc_pkg::OP_END_STOP, '0, '0);
  endtask

  // half-step rounding and the relative range window around the position
  task automatic test_rounding_and_range;
    apply_config(32'd1, 32'd1, axis_pos - 32'd1, axis_pos + 32'd1);
    send_cmd(smc_pkg::OP_ENABLE, '0, '0);
    send_cmd(smc_pkg::OP_MOVE_REL, -24'sd127, 16'd1);
    send_cmd(smc_pkg::OP_MOVE_REL, 24'd128, 16'd1);
    send_cmd(smc_pkg::OP_PULSE_DONE, '0, '0);
    send_cmd(smc_pkg::OP_ENABLE, '0, '0);
    send_cmd(smc_pkg::OP_MOVE_REL, -24'sd128, 16'd1);
    send_cmd(smc_pkg::OP_PULSE_DONE, '0, '0);
    send_cmd(smc_pkg::OP_ENABLE, '0, '0);
    send_cmd(smc_pkg::OP_MOVE_REL, 24'h7FFFFF, 16'hFFFF);
    send_cmd(smc_pkg::OP_MOVE_ABS, 24'h7FFFFF, 16'hFFFF);
    send_cmd(smc_pkg::OP_END_STOP, '0, '0);
  endtask

  // zero steps_per_mm, masked register writes, zero clock, prescaler saturation
  task automatic test_config_extremes;
    apply_config(32'd0, 32'h0FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_cmd(smc_pkg::OP_ENABLE, '0, '0);
    send_cmd(smc_pkg::OP_MOVE_REL, 24'd1000, 16'd1);
    send_cmd(smc_pkg::OP_MOVE_ABS, 24'd0, 16'd77);
    send_cmd(smc_pkg::OP_END_STOP, '0, '0);
    apply_config(32'hFFFF_FFFF, 32'hF000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
    send_cmd(smc_pkg::OP_ENABLE, '0, '0);
    send_cmd(smc_pkg::OP_MOVE_REL, 24'hFFFFFF, 16'hFFFF);
    send_cmd(smc_pkg::OP_END_STOP, '0, '0);
    apply_config(32'd1, 32'h0FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_cmd(smc_pkg::OP_ENABLE, '0, '0);
    send_cmd(smc_pkg::OP_MOVE_REL, 24'd0, 16'd1);
  endtask

  // receiver holds off while commands keep coming, so the input stalls
  task automatic test_backpressure;
    drain();
    set_idling(0, 0);
    @(negedge clk_i);
    hold_left = 400;
    @(posedge clk_i);
    send_cmd(smc_pkg::OP_ENABLE, '0, '0);
    send_cmd(smc_pkg::OP_MOVE_REL, 24'd4, 16'd300);
    for (int i = 0; i < 10; i++) send_cmd(smc_pkg::OP_PULSE_DONE, rand_tod(), rand_speed());
    send_cmd(smc_pkg::OP_END_STOP, '0, '0);
    drain();
  endtask

  // enable, a short move, its pulses with some interference, then cleanup
  task automatic run_move_sequence;
    logic [smc_pkg::OP_W-1:0]    mop;
    logic [smc_pkg::SPEED_W-1:0] spd;
    longint span;
    longint tgt;
    int     k;
    if (axis_moving) send_cmd(smc_pkg::OP_END_STOP, rand_tod(), rand_speed());
    if ($urandom_range(9) != 0) send_cmd(smc_pkg::OP_ENABLE, rand_tod(), rand_speed());
    if (cfg_spm == 0) span = 64;
    else span = (4096 / cfg_spm > 0) ? 4096 / cfg_spm : 1;
    tgt = longint'($urandom_range(32'(2 * span))) - span;
    case ($urandom_range(15))
      0:       spd = '0;
      1:       spd = 16'd1;
      2:       spd = 16'hFFFF;
      default: spd = rand_speed();
    endcase
    if ($urandom_range(1) == 1) begin
      mop = smc_pkg::OP_MOVE_REL;
    end else begin
      mop = smc_pkg::OP_MOVE_ABS;
      if (cfg_spm != 0) tgt = tgt + longint'($signed(axis_pos)) * 256 / longint'(cfg_spm);
      if (tgt > 8388607) tgt = 8388607;
      if (tgt < -8388608) tgt = -8388608;
    end
    send_cmd(mop, tgt[smc_pkg::TOD_W-1:0], spd);
    k = 0;
    while (axis_moving && k < PULSE_CAP) begin
      case ($urandom_range(19))
        0: send_cmd(smc_pkg::OP_DISABLE, rand_tod(), rand_speed());
        1: send_cmd($urandom_range(1) ? smc_pkg::OP_MOVE_ABS : smc_pkg::OP_MOVE_REL,
                    rand_tod(), rand_speed());
        2: send_cmd(smc_pkg::OP_ENABLE, rand_tod(), rand_speed());
        default: send_cmd(smc_pkg::OP_PULSE_DONE, rand_tod(), rand_speed());
      endcase
      k++;
    end
    if (axis_moving) send_cmd(smc_pkg::OP_END_STOP, rand_tod(), rand_speed());
    if ($urandom_range(7) == 0) send_cmd(smc_pkg::OP_PULSE_DONE, rand_tod(), rand_speed());
  endtask

  // mostly well-formed move sequences, the rest random words of any op
  task automatic test_random_traffic(input int n_cmds);
    int stop_at;
    stop_at = cmds_sent + n_cmds;
    while (cmds_sent < stop_at) begin
      if ($urandom_range(4) == 0) begin
        send_cmd(smc_pkg::OP_W'($urandom_range(7)), rand_tod(), rand_speed());
      end else begin
        run_move_sequence();
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_command_basics();
    test_rounding_and_range();
    test_config_extremes();
    test_backpressure();

    apply_config(32'd200, 32'd50_000_000, -32'sd1000, 32'sd1000);
    set_idling(0, 0);
    test_random_traffic(150);

    apply_config(32'd1, 32'd1, 32'h8000_0000, 32'h7FFF_FFFF);
    set_idling(68, 0);
    test_random_traffic(150);

    apply_config(32'd4096, 32'd200_000_000, -32'sd20, 32'sd20);
    set_idling(0, 68);
    test_random_traffic(150);

    apply_config($urandom, $urandom, -$urandom_range(5000), $urandom_range(5000));
    set_idling(21, 21);
    test_random_traffic(150);

    drain();
    $display("run covered %0d commands and %0d result words over %0d register writes",
             cmds_sent, results_seen, reg_writes);
    $display("moves started %0d, moves refused %0d (out of range %0d)",
             moves_started, moves_refused, range_refused);
    if (fail_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
